// ===== rtl/wtk_pkg.sv =====
// ----------------------------------------------------------------------------
// Weighted top-k probe select package
// Shared types, constants and payload structs.
// ----------------------------------------------------------------------------
package wtk_pkg;

  localparam int MaxSelected = 4;
  localparam int CountW = $clog2(MaxSelected + 1);
  localparam int SlotW = (MaxSelected > 1) ? $clog2(MaxSelected) : 1;

  localparam logic [1:0] KIND_PROBE = 2'd0;
  localparam logic [1:0] KIND_PROBE_END = 2'd1;
  localparam logic [1:0] KIND_END = 2'd2;

  localparam logic [1:0] REG_VIEW_X = 2'd0;
  localparam logic [1:0] REG_VIEW_Y = 2'd1;
  localparam logic [1:0] REG_VIEW_Z = 2'd2;

  localparam logic [47:0] D2_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [33:0] SCORE_ONE = 34'h100_0000;
  localparam logic [33:0] SCORE_EPS = 34'd17;

  typedef struct packed {
    logic [1:0] kind;
    logic signed [31:0] probe_x;
    logic signed [31:0] probe_y;
    logic signed [31:0] probe_z;
    logic [30:0] half_x;
    logic [30:0] half_y;
    logic [30:0] half_z;
    logic [15:0] importance;
  } in_item_t;

  typedef struct packed {
    logic [1:0] rank;
    logic [2:0] selected_count;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [30:0] out_half_x;
    logic [30:0] out_half_y;
    logic [30:0] out_half_z;
    logic [16:0] blend_weight;
    logic last_result;
  } out_item_t;

  typedef struct packed {
    logic valid;
    logic [31:0] score;
    logic [95:0] center;
    logic [92:0] half;
  } slot_t;

  typedef struct packed {
    logic insert;
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

// ===== rtl/wtk_divider.sv =====
// ----------------------------------------------------------------------------
// Weighted top-k restoring divider
// Unsigned 48-bit by 49-bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wtk_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [48:0] divisor,
  output logic        done,
  output logic [47:0] quotient
);
  logic [47:0] quo;
  logic [48:0] rem;
  logic [48:0] dvs;
  logic [5:0]  count;
  logic        running;
  logic [49:0] trial;

  assign trial = {rem, quo[47]} - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      running <= 1'b0;
      count <= '0;
    end else if (start) begin
      running <= 1'b1;
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
      count <= 6'd48;
    end else if (running) begin
      if (trial[49]) begin
        rem <= {rem[47:0], quo[47]};
        quo <= {quo[46:0], 1'b0};
      end else begin
        rem <= trial[48:0];
        quo <= {quo[46:0], 1'b1};
      end
      count <= count - 6'd1;
      if (count == 6'd1) begin
        running <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

// ===== rtl/wtk_cell.sv =====
// ----------------------------------------------------------------------------
// Weighted top-k slot cell
// One sorted slot; takes the new probe, its left neighbor, holds, or clears.
// ----------------------------------------------------------------------------
module wtk_cell (
  input  logic            clk,
  input  logic            rst,
  input  wtk_pkg::cell_ctrl_t ctrl,
  input  wtk_pkg::slot_t  left,
  input  wtk_pkg::slot_t  fresh,
  output wtk_pkg::slot_t  slot
);
  import wtk_pkg::*;

  logic beaten;

  // The new probe wins over this slot when it scores strictly higher or the slot is empty.
  assign beaten = !slot.valid || (fresh.score > slot.score);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      slot.valid <= 1'b0;
      slot.score <= '0;
    end else if (ctrl.insert && beaten) begin
      if (left.valid && !(fresh.score > left.score)) begin
        slot <= fresh;
      end else if (ctrl.shift) begin
        slot <= left;
      end else begin
        slot <= fresh;
      end
    end
  end
endmodule

// ===== rtl/weighted_top_k_probe_select_unit.sv =====
// ----------------------------------------------------------------------------
// Weighted top-k probe select unit
// Scores probes against a view point, keeps the best few, emits blend weights.
// ----------------------------------------------------------------------------
// A probe transfer keeps busy high while each axis offset is squared, while
// the shared one-bit-per-cycle divider forms the score (48 quotient bits) and
// during the insert. At the end of a list the kept scores are summed, then
// each kept probe needs one more 48-bit division for its blend weight; a
// tiny sum is first replaced by SCORE_ONE. Each result appears on the result
// ports for one cycle with strobe high; an end with no kept probe gives one
// empty result. Results cannot be held off.
// ----------------------------------------------------------------------------
module weighted_top_k_probe_select_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  wtk_pkg::in_item_t  in_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               strobe,
  output wtk_pkg::out_item_t result
);
  import wtk_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ = 3'd1;
  localparam logic [2:0] ST_DIV = 3'd2;
  localparam logic [2:0] ST_INS = 3'd3;
  localparam logic [2:0] ST_SUM = 3'd4;
  localparam logic [2:0] ST_EDIV = 3'd5;
  localparam logic [2:0] ST_EWAIT = 3'd6;

  logic [2:0] state;
  logic signed [31:0] view_x, view_y, view_z;
  in_item_t item;
  logic [1:0] axis;
  logic [47:0] d2;
  logic [SlotW-1:0] idx;
  logic [33:0] total;
  logic [CountW-1:0] kept;

  slot_t cells [MaxSelected];
  cell_ctrl_t ctrl [MaxSelected];
  slot_t fresh;
  logic [31:0] score;

  logic div_start, div_done;
  logic [47:0] div_a, div_q;
  logic [48:0] div_b;

  logic signed [32:0] diff;
  logic [32:0] mag;
  logic [65:0] sq;
  logic [48:0] d2_sum;
  slot_t cur;

  assign busy = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      view_x <= '0;
      view_y <= '0;
      view_z <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_VIEW_X: view_x <= cfg_data;
        REG_VIEW_Y: view_y <= cfg_data;
        REG_VIEW_Z: view_z <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (axis)
      2'd0: diff = 33'(item.probe_x) - 33'(view_x);
      2'd1: diff = 33'(item.probe_y) - 33'(view_y);
      default: diff = 33'(item.probe_z) - 33'(view_z);
    endcase
    mag = diff[32] ? 33'(-diff) : 33'(diff);
    sq = 66'(mag) * 66'(mag);
    d2_sum = {1'b0, d2} + {1'b0, sq[63:16]};
    cur = cells[idx];
  end

  assign score = div_q[31:0];
  assign fresh.valid = 1'b1;
  assign fresh.score = score;
  assign fresh.center = {item.probe_x, item.probe_y, item.probe_z};
  assign fresh.half = {item.half_x, item.half_y, item.half_z};

  genvar g;
  generate
    for (g = 0; g < MaxSelected; g++) begin : g_cell
      assign ctrl[g].insert = (state == ST_INS);
      assign ctrl[g].shift = (g != 0);
      assign ctrl[g].clear = (state == ST_EWAIT) && div_done &&
                             (32'(idx) + 1 == 32'(kept)) ||
                             (state == ST_IDLE) && start && !busy &&
                             (in_item.kind == KIND_END) && (kept == '0);
      wtk_cell u_cell (
        .clk(clk), .rst(rst), .ctrl(ctrl[g]),
        .left(g == 0 ? '0 : cells[(g == 0) ? 0 : g - 1]),
        .fresh(fresh), .slot(cells[g])
      );
    end
  endgenerate

  wtk_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a),
    .divisor(div_b), .done(div_done), .quotient(div_q)
  );

  always_comb begin
    div_start = 1'b0;
    div_a = {item.importance, 32'd0};
    div_b = 49'h1_0000 + {1'b0, d2};
    if (state == ST_SQ && axis == 2'd2) begin
      div_start = 1'b1;
      div_b = 49'h1_0000 + ((d2_sum > {1'b0, D2_MAX}) ? {1'b0, D2_MAX} : d2_sum);
    end else if (state == ST_EDIV) begin
      div_start = 1'b1;
      div_a = {cur.score, 16'd0};
      div_b = 49'(total);
    end
  end

  always_ff @(posedge clk) begin
    strobe <= 1'b0;
    if (rst) begin
      state <= ST_IDLE;
      kept <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            item <= in_item;
            axis <= 2'd0;
            d2 <= '0;
            if (in_item.kind == KIND_PROBE || in_item.kind == KIND_PROBE_END) begin
              state <= ST_SQ;
            end else if (in_item.kind == KIND_END) begin
              if (kept == '0) begin
                strobe <= 1'b1;
                result.rank <= '0;
                result.selected_count <= '0;
                result.out_x <= '0;
                result.out_y <= '0;
                result.out_z <= '0;
                result.out_half_x <= '0;
                result.out_half_y <= '0;
                result.out_half_z <= '0;
                result.blend_weight <= '0;
                result.last_result <= 1'b1;
              end else begin
                state <= ST_SUM;
                idx <= '0;
                total <= '0;
              end
            end
          end
        end
        ST_SQ: begin
          d2 <= (d2_sum > {1'b0, D2_MAX}) ? D2_MAX : d2_sum[47:0];
          axis <= axis + 2'd1;
          if (axis == 2'd2) state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) state <= ST_INS;
        end
        ST_INS: begin
          if (32'(kept) < MaxSelected) kept <= kept + 1'b1;
          if (item.kind == KIND_PROBE_END) begin
            state <= ST_SUM;
            idx <= '0;
            total <= '0;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_SUM: begin
          if (cur.valid) total <= total + 34'(cur.score);
          if (32'(idx) == MaxSelected - 1) begin
            idx <= '0;
            state <= ST_EDIV;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_EDIV: begin
          if (idx == '0 && total < SCORE_EPS) total <= SCORE_ONE;
          if (idx == '0 && total < SCORE_EPS) begin
            state <= ST_EDIV;
          end else begin
            state <= ST_EWAIT;
          end
        end
        ST_EWAIT: begin
          if (div_done) begin
            strobe <= 1'b1;
            result.rank <= 2'(idx);
            result.selected_count <= 3'(kept);
            result.out_x <= cur.center[95:64];
            result.out_y <= cur.center[63:32];
            result.out_z <= cur.center[31:0];
            result.out_half_x <= cur.half[92:62];
            result.out_half_y <= cur.half[61:31];
            result.out_half_z <= cur.half[30:0];
            result.blend_weight <= div_q[16:0];
            result.last_result <= (32'(idx) + 1 == 32'(kept));
            if (32'(idx) + 1 == 32'(kept)) begin
              kept <= '0;
              state <= ST_IDLE;
            end else begin
              idx <= idx + 1'b1;
              state <= ST_EDIV;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
